// ===== rtl/imk_pkg.sv =====
// Shared types, phase codes and reset values of the iambic keyer.
`timescale 1ns / 1ps

package imk_pkg;

   // Keyer phase codes
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_MARK  = 2'd1;
   localparam logic [1:0] PH_SPACE = 2'd2;
   localparam logic [1:0] PH_GAP   = 2'd3;

   // Register indexes on the configuration port
   localparam logic REG_UNIT_TICKS        = 1'b0;
   localparam logic REG_SQUEEZE_THRESHOLD = 1'b1;

   localparam logic [14:0] UNIT_TICKS_RESET        = 15'd1024;
   localparam logic [15:0] SQUEEZE_THRESHOLD_RESET = 16'd1024;
   localparam logic [15:0] COUNT_MAX               = 16'hFFFF;
   localparam logic [3:0]  ELEMENT_COUNT_MAX       = 4'd15;
   localparam logic [3:0]  ELEMENT_LIMIT           = 4'd7;
   localparam logic [7:0]  CODE_START              = 8'd1;

   typedef struct packed {
      logic [14:0] unit_ticks;
      logic [15:0] squeeze_threshold;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic        element_is_dah;
      logic [15:0] phase_timer;
      logic [15:0] dit_held_count;
      logic [15:0] dah_held_count;
      logic [7:0]  code_shift;
      logic [3:0]  element_count;
   } state_type;

   typedef struct packed {
      logic       key_down;
      logic       symbol_valid;
      logic [7:0] symbol_code;
      logic       symbol_error;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:          PH_IDLE,
      element_is_dah: 1'b0,
      phase_timer:    16'd0,
      dit_held_count: 16'd0,
      dah_held_count: 16'd0,
      code_shift:     CODE_START,
      element_count:  4'd0
   };

endpackage

// ===== rtl/imk_csr.sv =====
// APB-style register block holding the keyer timing settings.
`timescale 1ns / 1ps

module imk_csr
   import imk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   logic [14:0] unit_ticks_ff;
   logic [15:0] squeeze_threshold_ff;
   logic        wr_en;
   logic        reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_en   = psel && penable && pwrite && pready;

   // Write the addressed register on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff        <= UNIT_TICKS_RESET;
         squeeze_threshold_ff <= SQUEEZE_THRESHOLD_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_UNIT_TICKS:        unit_ticks_ff        <= pwdata[14:0];
            REG_SQUEEZE_THRESHOLD: squeeze_threshold_ff <= pwdata[15:0];
            default:               ;
         endcase
      end
   end

   // Return the addressed register, zero extended
   always_comb begin
      unique case (reg_sel)
         REG_UNIT_TICKS:        prdata = {17'd0, unit_ticks_ff};
         REG_SQUEEZE_THRESHOLD: prdata = {16'd0, squeeze_threshold_ff};
         default:               prdata = 32'd0;
      endcase
   end

   assign cfg.unit_ticks        = unit_ticks_ff;
   assign cfg.squeeze_threshold = squeeze_threshold_ff;

endmodule

// ===== rtl/imk_step.sv =====
// Next-state and result logic for one keyer tick.
`timescale 1ns / 1ps

module imk_step
   import imk_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  cur,
   input  logic       dit,
   input  logic       dah,
   output state_type  nxt,
   output result_type res
);

   logic [14:0] unit;
   logic [16:0] dah_len_wide;
   logic [15:0] mark_len;
   logic [15:0] gap_len;
   logic [15:0] timer_inc;
   logic [15:0] dit_cnt_inc;
   logic [15:0] dah_cnt_inc;
   logic        start;
   logic        start_dah;
   logic        sym_valid;
   logic        sym_error;
   logic        sym_emit;

   // Derive element lengths; a zero unit acts as one tick
   assign unit         = (cfg.unit_ticks == 15'd0) ? 15'd1 : cfg.unit_ticks;
   assign dah_len_wide = {2'd0, unit} + {1'b0, unit, 1'b0};
   assign gap_len      = {unit, 1'b0};
   always_comb begin
      if (!cur.element_is_dah) begin
         mark_len = {1'b0, unit};
      end else if (dah_len_wide[16]) begin
         mark_len = COUNT_MAX;
      end else begin
         mark_len = dah_len_wide[15:0];
      end
   end

   assign timer_inc   = cur.phase_timer + 16'd1;
   assign dit_cnt_inc = (dit && cur.dit_held_count != COUNT_MAX) ?
                        cur.dit_held_count + 16'd1 : cur.dit_held_count;
   assign dah_cnt_inc = (dah && cur.dah_held_count != COUNT_MAX) ?
                        cur.dah_held_count + 16'd1 : cur.dah_held_count;

   // Decide the phase move for this tick
   always_comb begin
      nxt       = cur;
      start     = 1'b0;
      start_dah = 1'b0;
      sym_valid = 1'b0;
      sym_error = 1'b0;
      sym_emit  = 1'b0;
      unique case (cur.phase)
         PH_IDLE: begin
            start     = dit || dah;
            start_dah = !dit;
         end
         PH_MARK: begin
            nxt.dit_held_count = dit_cnt_inc;
            nxt.dah_held_count = dah_cnt_inc;
            nxt.phase_timer    = timer_inc;
            if (timer_inc >= mark_len) begin
               nxt.phase       = PH_SPACE;
               nxt.phase_timer = 16'd0;
            end
         end
         PH_SPACE: begin
            nxt.dit_held_count = dit_cnt_inc;
            nxt.dah_held_count = dah_cnt_inc;
            nxt.phase_timer    = timer_inc;
            if (timer_inc >= {1'b0, unit}) begin
               if (!cur.element_is_dah && dah_cnt_inc > cfg.squeeze_threshold) begin
                  start     = 1'b1;
                  start_dah = 1'b1;
               end else if (cur.element_is_dah &&
                            dit_cnt_inc > cfg.squeeze_threshold) begin
                  start     = 1'b1;
                  start_dah = 1'b0;
               end else if (cur.element_count > ELEMENT_LIMIT) begin
                  sym_valid = 1'b1;
                  sym_error = 1'b1;
               end else if (dit || dah) begin
                  start     = 1'b1;
                  start_dah = !dit;
               end else begin
                  nxt.phase       = PH_GAP;
                  nxt.phase_timer = 16'd0;
               end
            end
         end
         PH_GAP: begin
            if (dit || dah) begin
               start     = 1'b1;
               start_dah = dah;
            end else begin
               nxt.phase_timer = timer_inc;
               if (timer_inc >= gap_len) begin
                  sym_valid = 1'b1;
                  sym_emit  = 1'b1;
               end
            end
         end
         default: ;
      endcase

      // Start a new element: shift its bit into the code
      if (start) begin
         nxt.element_is_dah = start_dah;
         nxt.phase          = PH_MARK;
         nxt.phase_timer    = 16'd0;
         nxt.dit_held_count = 16'd0;
         nxt.dah_held_count = 16'd0;
         nxt.code_shift     = {cur.code_shift[6:0], start_dah};
         if (cur.element_count != ELEMENT_COUNT_MAX) begin
            nxt.element_count = cur.element_count + 4'd1;
         end
      end

      // Close the character, whether emitted or dropped
      if (sym_valid) begin
         nxt.phase         = PH_IDLE;
         nxt.phase_timer   = 16'd0;
         nxt.code_shift    = CODE_START;
         nxt.element_count = 4'd0;
      end
   end

   assign res.key_down     = (nxt.phase == PH_MARK);
   assign res.symbol_valid = sym_valid;
   assign res.symbol_code  = sym_emit ? cur.code_shift : 8'd0;
   assign res.symbol_error = sym_error;

endmodule

// ===== rtl/imk_out_buf.sv =====
// Result register with a skid stage between the keyer and its consumer.
`timescale 1ns / 1ps

module imk_out_buf
   import imk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       push;
   logic       pop;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && in_ready;
   assign pop      = out_valid_ff && out_ready;

   // Refill the output from the skid stage first, else from the input
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // A held skid entry always sits behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a transaction with the output empty");

   // A transaction arriving on a stalled output lands in the skid stage
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !out_ready) |=> skid_valid_ff)
      else $error("transaction lost on a stalled output");

endmodule

// ===== rtl/iambic_morse_keyer.sv =====
// Top level of the iambic paddle keyer: registers, tick logic and result buffer.
`timescale 1ns / 1ps
//
// Channel   Handshake              Payload
// req       req_valid/req_ready    req_dit_paddle, req_dah_paddle (one tick)
// rsp       rsp_valid/rsp_ready    rsp_key_down, rsp_symbol_valid,
//                                  rsp_symbol_code[7:0], rsp_symbol_error
// csr       psel/penable/pwrite    paddr[2:0], pwdata, prdata; pready tied high
//
// One tick transaction is taken every cycle while req_ready is high; its result is
// registered in the output stage, or in the skid stage while rsp is stalled.
// The keyer state updates at the accepting edge.
// A stalled rsp is absorbed by a one-entry skid stage; req_ready drops only
// while that stage is full.
// Synchronous reset returns the keyer to idle with code 1 and the default
// timing registers.

module iambic_morse_keyer
   import imk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_dit_paddle,
   input  logic        req_dah_paddle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_key_down,
   output logic        rsp_symbol_valid,
   output logic [7:0]  rsp_symbol_code,
   output logic        rsp_symbol_error,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type    cfg;
   state_type  state_ff, state_in;
   result_type step_res;
   result_type rsp_data;
   logic       accept;

   imk_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   imk_step u_step (
      .cfg (cfg),
      .cur (state_ff),
      .dit (req_dit_paddle),
      .dah (req_dah_paddle),
      .nxt (state_in),
      .res (step_res)
   );

   assign accept = req_valid && req_ready;

   // Advance the keyer state on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   imk_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (step_res),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_key_down     = rsp_data.key_down;
   assign rsp_symbol_valid = rsp_data.symbol_valid;
   assign rsp_symbol_code  = rsp_data.symbol_code;
   assign rsp_symbol_error = rsp_data.symbol_error;

   // Idle always means a cleared character
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_IDLE) |->
      (state_ff.element_count == 4'd0 && state_ff.code_shift == CODE_START))
      else $error("idle keyer holds a partial character");

   // A sounding mark belongs to a counted element
   a_mark_counted: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_MARK) |-> (state_ff.element_count != 4'd0))
      else $error("mark without a counted element");

   // Without an accepted tick the keyer state holds
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(state_ff))
      else $error("keyer state moved without a tick");

endmodule

// ===== sim/iambic_morse_keyer_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the iambic keyer: paddle ticks in, key and symbol results checked.

module iambic_morse_keyer_test;
   import imk_pkg::*;

   localparam int RUN_LIMIT       = 600000;
   localparam int PRINT_CAP       = 40;
   localparam int HOLD_OFF_CYCLES = 80;

   typedef struct packed {
      logic dit;
      logic dah;
   } paddle_pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_dit_paddle = 1'b0;
   logic        req_dah_paddle = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_key_down;
   logic        rsp_symbol_valid;
   logic [7:0]  rsp_symbol_code;
   logic        rsp_symbol_error;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   iambic_morse_keyer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_dit_paddle   (req_dit_paddle),
      .req_dah_paddle   (req_dah_paddle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_down     (rsp_key_down),
      .rsp_symbol_valid (rsp_symbol_valid),
      .rsp_symbol_code  (rsp_symbol_code),
      .rsp_symbol_error (rsp_symbol_error),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // Pending paddle ticks and the key results they are due to produce
   paddle_pair_type paddle_ticks[$];
   result_type      ticks_due[$];

   // Shadow of the keyer and its timing registers
   state_type   keyer = STATE_RESET;
   logic [14:0] unit_cfg = UNIT_TICKS_RESET;
   logic [15:0] thr_cfg = SQUEEZE_THRESHOLD_RESET;

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hold_len = 0;
   int   hold_cnt = 0;
   logic req_taken = 1'b0;
   int   cycle_count = 0;
   int   mismatch_count = 0;
   int   ticks_sent = 0;
   int   ticks_checked = 0;
   int   symbols_seen = 0;
   int   overlong_seen = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Report one mismatch and count it
   task automatic flag_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < PRINT_CAP)
         $display("MISMATCH %s: got %0d, want %0d (cycle %0d, result %0d)",
                  what, got, want, cycle_count, ticks_checked);
      mismatch_count++;
   endtask

   // Keyer prediction
   function automatic void begin_element(input logic as_dah);
      keyer.element_is_dah = as_dah;
      keyer.phase          = PH_MARK;
      keyer.phase_timer    = '0;
      keyer.dit_held_count = '0;
      keyer.dah_held_count = '0;
      keyer.code_shift     = {keyer.code_shift[6:0], as_dah};
      if (keyer.element_count < ELEMENT_COUNT_MAX)
         keyer.element_count = keyer.element_count + 4'd1;
   endfunction

   function automatic void end_character();
      keyer.phase         = PH_IDLE;
      keyer.phase_timer   = '0;
      keyer.code_shift    = CODE_START;
      keyer.element_count = '0;
   endfunction

   function automatic void count_held(input logic dit, input logic dah);
      if (dit && keyer.dit_held_count != COUNT_MAX)
         keyer.dit_held_count = keyer.dit_held_count + 16'd1;
      if (dah && keyer.dah_held_count != COUNT_MAX)
         keyer.dah_held_count = keyer.dah_held_count + 16'd1;
   endfunction

   function automatic result_type predict_tick(input logic dit, input logic dah);
      result_type res;
      int         unit_len;
      int         mark_len;
      res      = '0;
      unit_len = (unit_cfg == '0) ? 1 : int'(unit_cfg);
      case (keyer.phase)
         PH_IDLE: begin
            // dit wins when both are pressed from idle
            if (dit)
               begin_element(1'b0);
            else if (dah)
               begin_element(1'b1);
         end
         PH_MARK: begin
            mark_len = keyer.element_is_dah ? 3 * unit_len : unit_len;
            if (mark_len > int'(COUNT_MAX))
               mark_len = int'(COUNT_MAX);
            count_held(dit, dah);
            keyer.phase_timer = keyer.phase_timer + 16'd1;
            if (int'(keyer.phase_timer) >= mark_len) begin
               keyer.phase       = PH_SPACE;
               keyer.phase_timer = '0;
            end
         end
         PH_SPACE: begin
            count_held(dit, dah);
            keyer.phase_timer = keyer.phase_timer + 16'd1;
            if (int'(keyer.phase_timer) >= unit_len) begin
               // squeeze, then overlong check, then fresh presses, else gap
               if (!keyer.element_is_dah && keyer.dah_held_count > thr_cfg)
                  begin_element(1'b1);
               else if (keyer.element_is_dah && keyer.dit_held_count > thr_cfg)
                  begin_element(1'b0);
               else if (keyer.element_count > ELEMENT_LIMIT) begin
                  res.symbol_valid = 1'b1;
                  res.symbol_error = 1'b1;
                  end_character();
               end else if (dit)
                  begin_element(1'b0);
               else if (dah)
                  begin_element(1'b1);
               else begin
                  keyer.phase       = PH_GAP;
                  keyer.phase_timer = '0;
               end
            end
         end
         default: begin
            // in the gap dah wins over dit
            if (dah)
               begin_element(1'b1);
            else if (dit)
               begin_element(1'b0);
            else begin
               keyer.phase_timer = keyer.phase_timer + 16'd1;
               if (int'(keyer.phase_timer) >= 2 * unit_len) begin
                  res.symbol_valid = 1'b1;
                  res.symbol_code  = keyer.code_shift;
                  end_character();
               end
            end
         end
      endcase
      res.key_down = (keyer.phase == PH_MARK);
      return res;
   endfunction

   // Drive paddle ticks, holding each one until it is taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (paddle_ticks.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_valid      <= 1'b1;
            req_dit_paddle <= paddle_ticks[0].dit;
            req_dah_paddle <= paddle_ticks[0].dah;
            void'(paddle_ticks.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predict each accepted tick
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         ticks_due.push_back(predict_tick(req_dit_paddle, req_dah_paddle));
         ticks_sent++;
      end
   end

   // Stall the result side at random, or hard during a hold-off
   always @(negedge clock) begin
      if (hold_cnt < hold_len)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (hold_cnt < hold_len)
         hold_cnt <= hold_cnt + 1;
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (ticks_due.size() == 0) begin
            flag_mismatch("result with nothing due", 1, 0);
         end else begin
            if (rsp_key_down !== ticks_due[0].key_down)
               flag_mismatch("key_down", rsp_key_down, ticks_due[0].key_down);
            if (rsp_symbol_valid !== ticks_due[0].symbol_valid)
               flag_mismatch("symbol_valid", rsp_symbol_valid, ticks_due[0].symbol_valid);
            if (rsp_symbol_code !== ticks_due[0].symbol_code)
               flag_mismatch("symbol_code", rsp_symbol_code, ticks_due[0].symbol_code);
            if (rsp_symbol_error !== ticks_due[0].symbol_error)
               flag_mismatch("symbol_error", rsp_symbol_error, ticks_due[0].symbol_error);
            if (ticks_due[0].symbol_valid)
               symbols_seen++;
            if (ticks_due[0].symbol_error)
               overlong_seen++;
            ticks_checked++;
            void'(ticks_due.pop_front());
         end
      end
   end

   // Run limit
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("Run limit reached with %0d results outstanding", ticks_due.size());
      $display("DONE: errors detected");
      $finish;
   end

   task automatic push_run(input logic dit, input logic dah, input int count);
      repeat (count) paddle_ticks.push_back(paddle_pair_type'{dit, dah});
   endtask

   // Write a timing register, then read it back
   task automatic program_reg(input logic index, input logic [31:0] value);
      logic [31:0] kept;
      kept = (index == REG_UNIT_TICKS) ? {17'b0, value[14:0]} : {16'b0, value[15:0]};
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (index == REG_UNIT_TICKS)
         unit_cfg = kept[14:0];
      else
         thr_cfg = kept[15:0];
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== kept)
         flag_mismatch("register read-back", prdata, kept);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Queue runs of held paddles with gaps between, plus some single-tick noise
   task automatic load_random_ticks(input int count);
      int unit_len;
      int long_cap;
      int pattern;
      int run_len;
      int added;
      unit_len = (unit_cfg == '0) ? 1 : int'(unit_cfg);
      long_cap = (unit_len <= 3) ? 20 * unit_len : 60;
      added    = 0;
      while (added < count) begin
         if ($urandom_range(99, 0) < 10) begin
            run_len = 1;
            push_run(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), run_len);
         end else begin
            pattern = $urandom_range(3, 0);
            if ($urandom_range(1, 0))
               run_len = $urandom_range(2 * unit_len + 1, 1);
            else
               run_len = $urandom_range(long_cap, 1);
            push_run(pattern[0], pattern[1], run_len);
         end
         added += run_len;
      end
   endtask

   // Wait until every queued tick is taken and every result checked
   task automatic drain();
      while (paddle_ticks.size() != 0 || req_valid || ticks_due.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic random_phase(input logic [31:0] unit_word, input logic [31:0] thr_word,
                               input int count, input int hold_off);
      program_reg(REG_UNIT_TICKS, unit_word);
      program_reg(REG_SQUEEZE_THRESHOLD, thr_word);
      load_random_ticks(count);
      if (hold_off > 0)
         hold_len = hold_cnt + hold_off;
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver heavily
      send_idle_pct = 28;
      recv_idle_pct = 55;

      // Directed: zero unit length acts as one, squeeze on any held count
      program_reg(REG_UNIT_TICKS, 32'd0);
      program_reg(REG_SQUEEZE_THRESHOLD, 32'd0);
      push_run(1'b1, 1'b1, 1);   // both pressed from idle: dit first
      push_run(1'b0, 1'b1, 2);   // dah held through dit: squeeze a dah
      push_run(1'b0, 1'b0, 6);   // finish dah, then gap ends the character
      push_run(1'b0, 1'b1, 1);   // lone dah from idle
      push_run(1'b1, 1'b0, 16);  // dit held on: squeeze, then overlong character
      push_run(1'b0, 1'b0, 4);
      drain();

      random_phase(32'd1, 32'd0, 290, 0);
      // upper bits of the written words must be dropped
      random_phase(32'hABCD_8002, 32'h0001_0001, 290, 0);

      // Sender idles heavily, receiver lightly
      send_idle_pct = 55;
      recv_idle_pct = 28;
      random_phase(32'd3, 32'hFFFF, 280, 0);
      random_phase(32'd1, 32'd2, 280, 0);

      // No idling; one long receiver hold-off to back the keyer up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(32'd4, 32'd3, 280, HOLD_OFF_CYCLES);
      random_phase(32'd2, 32'd0, 280, 0);

      // Longest unit and top threshold: a dah from idle stays keyed
      program_reg(REG_UNIT_TICKS, 32'h7FFF);
      program_reg(REG_SQUEEZE_THRESHOLD, 32'hFFFF);
      push_run(1'b0, 1'b1, 1);
      push_run(1'b1, 1'b1, 30);
      push_run(1'b0, 1'b0, 10);

      while (paddle_ticks.size() != 0 || req_valid)
         @(posedge clock);
      for (int i = 0; i < 500 && ticks_due.size() != 0; i++)
         @(posedge clock);
      repeat (5) @(posedge clock);
      if (ticks_due.size() != 0)
         flag_mismatch("results never arrived", ticks_due.size(), 0);

      $display("Sent %0d paddle ticks over eight timing settings, checked %0d results",
               ticks_sent, ticks_checked);
      $display("Characters closed: %0d, of which %0d were overlong", symbols_seen,
               overlong_seen);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
